[design/rvx_pkg.sv]
// Shared types and decode constants for the RV32 subset execute step.
package rvx_pkg;

	// Register file geometry (fixed by the instruction format)
	localparam int REG_COUNT = 32;
	localparam int RAW       = 5;
	localparam int XLEN      = 32;

	// Major opcodes
	localparam logic [6:0] OPC_R      = 7'b0110011;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JUMP   = 7'b1101111;

	// funct7 codes for R-type
	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_MUL  = 7'b0000001;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	// funct3 codes for R-type
	localparam logic [2:0] F3_ADD = 3'b000;
	localparam logic [2:0] F3_OR  = 3'b110;
	localparam logic [2:0] F3_AND = 3'b111;

	typedef enum logic [2:0] {
		CLS_R      = 3'd0,
		CLS_IMM    = 3'd1,
		CLS_LOAD   = 3'd2,
		CLS_STORE  = 3'd3,
		CLS_BRANCH = 3'd4,
		CLS_JUMP   = 3'd5,
		CLS_NONE   = 3'd6
	} op_class_t;

	// One executed instruction, as reported on the result channel
	typedef struct packed {
		logic [XLEN-1:0]        instr_pc;
		logic [XLEN-1:0]        next_pc;
		op_class_t              op_class;
		logic                   reg_write;
		logic [RAW-1:0]         reg_index;
		logic signed [XLEN-1:0] reg_value;
		logic                   mem_write;
		logic signed [XLEN-1:0] mem_address;
		logic signed [XLEN-1:0] mem_data;
		logic                   branch_taken;
	} result_t;

endpackage

[design/rvx_if.sv]
// Instruction request channel
interface rvx_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink (input valid, input instr_word, output ready);
endinterface

// Result request channel
interface rvx_result_if;
	logic               valid;
	logic               ready;
	logic [31:0]        instr_pc;
	logic [31:0]        next_pc;
	logic [2:0]         op_class;
	logic               reg_write;
	logic [4:0]         reg_index;
	logic signed [31:0] reg_value;
	logic               mem_write;
	logic signed [31:0] mem_address;
	logic signed [31:0] mem_data;
	logic               branch_taken;

	modport source (
		output valid, output instr_pc, output next_pc, output op_class,
		output reg_write, output reg_index, output reg_value, output mem_write,
		output mem_address, output mem_data, output branch_taken,
		input ready
	);
	modport sink (
		input valid, input instr_pc, input next_pc, input op_class,
		input reg_write, input reg_index, input reg_value, input mem_write,
		input mem_address, input mem_data, input branch_taken,
		output ready
	);
endinterface

[design/rvx_ram.sv]
// Simple dual-port RAM: one write port, one read port, registered read data.
module rvx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/rvx_exec.sv]
// Decode and execute of one instruction from its operands and PC.
// Loads leave reg_value and mem_data at zero; the data store fills them later.
module rvx_exec (
	input  logic [31:0]      instr_word,
	input  logic [31:0]      pc,
	input  logic [31:0]      rs1_val,
	input  logic [31:0]      rs2_val,
	output rvx_pkg::result_t res
);

	logic [6:0]  opc;
	logic [6:0]  f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] prod;
	logic [31:0] r_val;
	logic [31:0] pc_inc;

	assign opc = instr_word[6:0];
	assign rd  = instr_word[11:7];
	assign f3  = instr_word[14:12];
	assign f7  = instr_word[31:25];

	// Immediate formats
	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
		instr_word[30:25], instr_word[11:8], 1'b0};
	assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
		instr_word[20], instr_word[30:21], 1'b0};

	assign prod   = rs1_val * rs2_val;
	assign pc_inc = pc + 32'd4;

	// R-type function; unknown pairs give zero
	always_comb begin
		r_val = '0;
		case (f3)
			rvx_pkg::F3_ADD: begin
				if (f7 == rvx_pkg::F7_BASE) begin
					r_val = rs1_val + rs2_val;
				end else if (f7 == rvx_pkg::F7_ALT) begin
					r_val = rs1_val - rs2_val;
				end else if (f7 == rvx_pkg::F7_MUL) begin
					r_val = prod;
				end
			end
			rvx_pkg::F3_AND: begin
				if (f7 == rvx_pkg::F7_BASE) begin
					r_val = rs1_val & rs2_val;
				end
			end
			rvx_pkg::F3_OR: begin
				if (f7 == rvx_pkg::F7_BASE) begin
					r_val = rs1_val | rs2_val;
				end
			end
			default: r_val = '0;
		endcase
	end

	// Main decode
	always_comb begin
		res              = '0;
		res.instr_pc     = pc;
		res.next_pc      = pc_inc;
		res.op_class     = rvx_pkg::CLS_NONE;
		unique case (opc)
			rvx_pkg::OPC_R: begin
				res.op_class  = rvx_pkg::CLS_R;
				res.reg_write = 1'b1;
				res.reg_index = rd;
				res.reg_value = $signed(r_val);
			end
			rvx_pkg::OPC_IMM: begin
				res.op_class  = rvx_pkg::CLS_IMM;
				res.reg_write = 1'b1;
				res.reg_index = rd;
				res.reg_value = $signed(rs1_val + imm_i);
			end
			rvx_pkg::OPC_LOAD: begin
				res.op_class    = rvx_pkg::CLS_LOAD;
				res.reg_write   = 1'b1;
				res.reg_index   = rd;
				res.mem_address = $signed(rs1_val + imm_i);
			end
			rvx_pkg::OPC_STORE: begin
				res.op_class    = rvx_pkg::CLS_STORE;
				res.mem_write   = 1'b1;
				res.mem_address = $signed(rs1_val + imm_s);
				res.mem_data    = $signed(rs2_val);
			end
			rvx_pkg::OPC_BRANCH: begin
				res.op_class = rvx_pkg::CLS_BRANCH;
				if (rs1_val == rs2_val) begin
					res.next_pc      = pc + imm_b;
					res.branch_taken = 1'b1;
				end
			end
			rvx_pkg::OPC_JUMP: begin
				res.op_class     = rvx_pkg::CLS_JUMP;
				res.next_pc      = pc + imm_j;
				res.branch_taken = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[design/rv32_subset_execute_step.sv]
// Executes one RV32 subset instruction per request, in program order, and reports
// one result per instruction, including the PC it was fetched at and the next PC.
// After reset the block clears all of the data store and register file and takes no
// request until it is done. A load goes through a second stage for the registered
// data store read and holds off new requests until it completes; other instructions
// complete in the first stage. Register reads are issued as the request is taken and
// the last register write is forwarded. A stalled result register holds the pipeline.
// The data store is indexed by the low log2(DATA_WORDS) bits of the byte address, so
// DATA_WORDS must be a power of two. Register x0 is writable.
module rv32_subset_execute_step #(
	parameter int DATA_WORDS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	rvx_instr_if.sink           instr,
	rvx_result_if.source        result
);

	localparam int DAW       = $clog2(DATA_WORDS);
	localparam int CLR_DEPTH = (DATA_WORDS > rvx_pkg::REG_COUNT) ? DATA_WORDS
		: rvx_pkg::REG_COUNT;
	localparam int CAW       = $clog2(CLR_DEPTH);
	localparam int RAW       = rvx_pkg::RAW;

	// Clearing pass
	logic [CAW-1:0] clr_cnt_q;
	logic           clr_done_q;

	// Pipeline
	logic             vld_s1;
	logic [31:0]      instr_s1;
	logic             vld_s2;
	rvx_pkg::result_t res_s2;
	logic [31:0]      pc_q;

	// Forwarding of the most recent register write
	logic           byp_v_q;
	logic [RAW-1:0] byp_idx_q;
	logic [31:0]    byp_val_q;

	// Output register
	logic             out_v_q;
	rvx_pkg::result_t out_q;

	// Memory ports
	logic           rf_we;
	logic [RAW-1:0] rf_waddr;
	logic [31:0]    rf_wdata;
	logic [31:0]    rf_a_rdata;
	logic [31:0]    rf_b_rdata;
	logic           dm_we;
	logic [DAW-1:0] dm_waddr;
	logic [31:0]    dm_wdata;
	logic           dm_re;
	logic [DAW-1:0] dm_raddr;
	logic [31:0]    dm_rdata;

	logic             accept;
	logic             can_emit;
	logic             s1_is_load;
	logic             s1_fire;
	logic             s1_to_s2;
	logic             s1_leave;
	logic             s2_fire;
	logic [31:0]      rs1_val;
	logic [31:0]      rs2_val;
	rvx_pkg::result_t ex_res;
	rvx_pkg::result_t ld_res;

	// Handshake and stage movement
	assign can_emit   = !out_v_q || result.ready;
	assign s1_is_load = (ex_res.op_class == rvx_pkg::CLS_LOAD);
	assign s1_fire    = vld_s1 && !s1_is_load && can_emit;
	assign s1_to_s2   = vld_s1 && s1_is_load && !vld_s2;
	assign s1_leave   = s1_fire || s1_to_s2;
	assign s2_fire    = vld_s2 && can_emit;
	assign instr.ready = clr_done_q && (!vld_s1 || s1_fire) && (!vld_s2 || s2_fire);
	assign accept     = instr.valid && instr.ready;

	// Register file, duplicated for two read ports
	rvx_ram #(.WIDTH(32), .DEPTH(rvx_pkg::REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (accept),
		.raddr (instr.instr_word[19:15]),
		.rdata (rf_a_rdata)
	);

	rvx_ram #(.WIDTH(32), .DEPTH(rvx_pkg::REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (accept),
		.raddr (instr.instr_word[24:20]),
		.rdata (rf_b_rdata)
	);

	// Data store
	rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (dm_raddr),
		.rdata (dm_rdata)
	);

	// Operand forwarding from the last register write
	assign rs1_val = (byp_v_q && byp_idx_q == instr_s1[19:15]) ? byp_val_q : rf_a_rdata;
	assign rs2_val = (byp_v_q && byp_idx_q == instr_s1[24:20]) ? byp_val_q : rf_b_rdata;

	rvx_exec u_exec (
		.instr_word (instr_s1),
		.pc         (pc_q),
		.rs1_val    (rs1_val),
		.rs2_val    (rs2_val),
		.res        (ex_res)
	);

	// Load completion takes the data store word
	always_comb begin
		ld_res           = res_s2;
		ld_res.reg_value = $signed(dm_rdata);
		ld_res.mem_data  = $signed(dm_rdata);
	end

	// Register file write port
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = '0;
		rf_wdata = '0;
		if (!clr_done_q) begin
			rf_we    = 1'b1;
			rf_waddr = clr_cnt_q[RAW-1:0];
		end else if (s2_fire) begin
			rf_we    = 1'b1;
			rf_waddr = res_s2.reg_index;
			rf_wdata = dm_rdata;
		end else if (s1_fire && ex_res.reg_write) begin
			rf_we    = 1'b1;
			rf_waddr = ex_res.reg_index;
			rf_wdata = $unsigned(ex_res.reg_value);
		end
	end

	// Data store ports
	always_comb begin
		dm_we    = 1'b0;
		dm_waddr = '0;
		dm_wdata = '0;
		if (!clr_done_q) begin
			dm_we    = 1'b1;
			dm_waddr = clr_cnt_q[DAW-1:0];
		end else if (s1_fire && ex_res.mem_write) begin
			dm_we    = 1'b1;
			dm_waddr = ex_res.mem_address[DAW-1:0];
			dm_wdata = $unsigned(ex_res.mem_data);
		end
	end

	assign dm_re    = s1_to_s2;
	assign dm_raddr = ex_res.mem_address[DAW-1:0];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			pc_q       <= '0;
			byp_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (!clr_done_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CAW'(CLR_DEPTH - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_leave) begin
				vld_s1 <= 1'b0;
			end
			if (s1_to_s2) begin
				vld_s2 <= 1'b1;
			end else if (s2_fire) begin
				vld_s2 <= 1'b0;
			end
			if (s1_leave) begin
				pc_q <= ex_res.next_pc;
			end
			if (clr_done_q && rf_we) begin
				byp_v_q <= 1'b1;
			end
			if (s1_fire || s2_fire) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr.instr_word;
		end
		if (s1_to_s2) begin
			res_s2 <= ex_res;
		end
		if (clr_done_q && rf_we) begin
			byp_idx_q <= rf_waddr;
			byp_val_q <= rf_wdata;
		end
		if (s2_fire) begin
			out_q <= ld_res;
		end else if (s1_fire) begin
			out_q <= ex_res;
		end
	end

	assign result.valid        = out_v_q;
	assign result.instr_pc     = out_q.instr_pc;
	assign result.next_pc      = out_q.next_pc;
	assign result.op_class     = out_q.op_class;
	assign result.reg_write    = out_q.reg_write;
	assign result.reg_index    = out_q.reg_index;
	assign result.reg_value    = out_q.reg_value;
	assign result.mem_write    = out_q.mem_write;
	assign result.mem_address  = out_q.mem_address;
	assign result.mem_data     = out_q.mem_data;
	assign result.branch_taken = out_q.branch_taken;

	// Checks
	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2))
		else $error("both pipeline stages hold an instruction");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> clr_done_q)
		else $error("request taken during clearing pass");

	a_s2_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(vld_s1 && s1_is_load))
		else $error("second stage entered without a load");

	a_store_only: assert property (@(posedge clk) disable iff (!arst_n)
		(dm_we && clr_done_q) |-> (vld_s1 && ex_res.op_class == rvx_pkg::CLS_STORE))
		else $error("data store written by a non-store");

endmodule
